@@ hw/rtl/pnoge_pkg.sv @@
// Package: widths, reset values, register indexes and shared types of the EMA filter.
`timescale 1ns / 1ps

package pnoge_pkg;

    localparam int NODE_COUNT_DEF = 4;

    localparam int NODE_W   = 2;
    localparam int MM_W     = 32;
    localparam int FILT_W   = 40;
    localparam int FRAC_W   = 8;
    localparam int ALPHA_W  = 9;
    localparam int JUMP_W   = 16;
    localparam int LIMIT_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Number of addressable node slots given the width of the node field
    localparam int NODE_SLOTS = 1 << NODE_W;

    localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(141);
    localparam logic [JUMP_W-1:0]  JUMP_RST  = JUMP_W'(800);
    localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(100000);

    localparam logic [FILT_W-1:0] FILT_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA       = 2'd0,
        CFG_MAX_JUMP    = 2'd1,
        CFG_FIRST_LIMIT = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha_q8;
        logic [JUMP_W-1:0]  max_jump_mm;
        logic [LIMIT_W-1:0] first_limit_mm;
    } t_cfg;

    typedef struct packed {
        logic              seeded;
        logic [FILT_W-1:0] filt;
    } t_node_state;

    typedef struct packed {
        t_node_state state;
        logic        rejected;
    } t_update;

endpackage

@@ hw/rtl/pnoge_sample_if.sv @@
// Input channel: one range report per transfer.
`timescale 1ns / 1ps

interface pnoge_sample_if import pnoge_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] node_index;
    logic [MM_W-1:0]   range_mm;

    modport source (output valid, output node_index, output range_mm, input ready);
    modport sink   (input valid, input node_index, input range_mm, output ready);
endinterface

@@ hw/rtl/pnoge_result_if.sv @@
// Output channel: one filter result per transfer.
`timescale 1ns / 1ps

interface pnoge_result_if import pnoge_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              node_seeded;
    logic [FILT_W-1:0] filtered_q8;
    logic              reading_rejected;

    modport source (output valid, output node_seeded, output filtered_q8,
                    output reading_rejected, input ready);
    modport sink   (input valid, input node_seeded, input filtered_q8,
                    input reading_rejected, output ready);
endinterface

@@ hw/rtl/pnoge_cfg_if.sv @@
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface pnoge_cfg_if import pnoge_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/per_node_outlier_gated_ema_filter.sv @@
// Top level: per-node outlier-gated EMA filter with input and result registers.
// Results: a reading is captured in the input register at its transfer; one combinational
// pass feeds the result register, which loads when the result slot is free or being taken.
// Throughput: one reading per cycle while the result is not held by back-pressure; the
// node store is updated at the same edge as the result register, so a reading of the same
// node in the next cycle sees it. Reset: synchronous, active low; clears all nodes to
// unseeded/zero and loads the register defaults (alpha 141, jump 800 mm, first limit 100000 mm). No clearing pass.
`timescale 1ns / 1ps

module per_node_outlier_gated_ema_filter import pnoge_pkg::*; #(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pnoge_cfg_if.sink      i_cfg,
    pnoge_sample_if.sink   i_sample,
    pnoge_result_if.source o_result
);

    // Only nodes reachable through the index field get storage
    localparam int STORE_DEPTH = (NODE_COUNT < NODE_SLOTS) ? NODE_COUNT : NODE_SLOTS;
    localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    t_cfg              r_cfg;
    logic              r_in_valid;
    logic [NODE_W-1:0] r_in_node;
    logic [MM_W-1:0]   r_in_mm;
    logic              r_out_valid;
    logic              r_out_seeded;
    logic [FILT_W-1:0] r_out_filt;
    logic              r_out_rej;
    logic              r_seeded [STORE_DEPTH];
    logic [FILT_W-1:0] r_filt   [STORE_DEPTH];

    logic              advance;
    logic              in_range;
    logic [IDX_W-1:0]  idx;
    t_node_state       cur_state;
    t_update           upd;
    t_update           n_result;

    assign i_cfg.ready    = 1'b1;
    assign advance        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_sample.ready = !r_in_valid || advance;

    assign in_range = (int'(r_in_node) < NODE_COUNT);
    assign idx      = in_range ? r_in_node[IDX_W-1:0] : '0;

    always_comb begin
        cur_state.seeded = r_seeded[idx];
        cur_state.filt   = r_filt[idx];
    end

    pnoge_update u_update (
        .i_cfg      (r_cfg),
        .i_state    (cur_state),
        .i_range_mm (r_in_mm),
        .o_update   (upd)
    );

    // Unknown node: reported unseeded, zero, rejected
    always_comb begin
        if (in_range) begin
            n_result = upd;
        end else begin
            n_result = '{state: '{seeded: 1'b0, filt: '0}, rejected: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{alpha_q8: ALPHA_RST, max_jump_mm: JUMP_RST,
                       first_limit_mm: LIMIT_RST};
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_ALPHA:       r_cfg.alpha_q8       <= i_cfg.data[ALPHA_W-1:0];
                CFG_MAX_JUMP:    r_cfg.max_jump_mm    <= i_cfg.data[JUMP_W-1:0];
                CFG_FIRST_LIMIT: r_cfg.first_limit_mm <= i_cfg.data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_sample.ready) begin
                r_in_valid <= i_sample.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_in_node <= i_sample.node_index;
            r_in_mm   <= i_sample.range_mm;
        end
        if (advance) begin
            r_out_seeded <= n_result.state.seeded;
            r_out_filt   <= n_result.state.filt;
            r_out_rej    <= n_result.rejected;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STORE_DEPTH; k++) begin
                r_seeded[k] <= 1'b0;
                r_filt[k]   <= '0;
            end
        end else if (advance && in_range) begin
            r_seeded[idx] <= upd.state.seeded;
            r_filt[idx]   <= upd.state.filt;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.node_seeded      = r_out_seeded;
    assign o_result.filtered_q8      = r_out_filt;
    assign o_result.reading_rejected = r_out_rej;

endmodule

@@ hw/rtl/pnoge_update.sv @@
// Per-reading datapath: seeding check, outlier gate and EMA update with saturation.
`timescale 1ns / 1ps

module pnoge_update import pnoge_pkg::*; (
    input  t_cfg              i_cfg,
    input  t_node_state       i_state,
    input  logic [MM_W-1:0]   i_range_mm,
    output t_update           o_update
);

    localparam int DIFF_W = FILT_W + 1;
    // |d| is below 2^24 whenever the update is taken
    localparam int DS_W   = JUMP_W + FRAC_W + 1;
    localparam int PROD_W = DS_W + ALPHA_W + 1;
    localparam int SUM_W  = FILT_W + 2;

    logic [FILT_W-1:0]        raw;
    logic signed [DIFF_W-1:0] diff;
    logic [FILT_W-1:0]        mag;
    logic [FILT_W-1:0]        thresh;
    logic                     outlier;
    logic                     first_ok;
    logic signed [DS_W-1:0]   diff_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  sum;
    logic [FILT_W-1:0]        blended;

    always_comb begin
        raw    = {i_range_mm, {FRAC_W{1'b0}}};
        diff   = $signed({1'b0, raw}) - $signed({1'b0, i_state.filt});
        mag    = diff[DIFF_W-1] ? FILT_W'(-diff) : diff[FILT_W-1:0];
        thresh = FILT_W'({i_cfg.max_jump_mm, {FRAC_W{1'b0}}});
        outlier = (mag >= thresh);

        first_ok = (i_range_mm != '0) && (i_range_mm < i_cfg.first_limit_mm);

        diff_s = diff[DS_W-1:0];
        prod   = $signed({1'b0, i_cfg.alpha_q8}) * diff_s;
        // arithmetic shift floors towards minus infinity
        sum    = $signed({2'b00, i_state.filt})
               + SUM_W'($signed(prod[PROD_W-1:FRAC_W]));
        if (sum[SUM_W-1]) begin
            blended = '0;
        end else if (sum[SUM_W-2]) begin
            blended = FILT_MAX;
        end else begin
            blended = sum[FILT_W-1:0];
        end

        o_update = '{state: i_state, rejected: 1'b0};
        if (!i_state.seeded) begin
            if (first_ok) begin
                o_update.state.seeded = 1'b1;
                o_update.state.filt   = raw;
            end else begin
                o_update.rejected = 1'b1;
            end
        end else if (outlier) begin
            o_update.rejected = 1'b1;
        end else begin
            o_update.state.filt = blended;
        end
    end

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the per-node outlier-gated EMA filter.
`timescale 1ns / 1ps

module tb;
    import pnoge_pkg::*;

    localparam int NODE_COUNT  = NODE_COUNT_DEF;
    localparam int CLK_PERIOD  = 20;
    localparam int RST_CYCLES  = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 8;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [MM_W-1:0]   mm;
    } t_reading;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pnoge_cfg_if    cfg_if ();
    pnoge_sample_if smp_if ();
    pnoge_result_if res_if ();

    per_node_outlier_gated_ema_filter #(
        .NODE_COUNT (NODE_COUNT)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_if),
        .i_sample (smp_if),
        .o_result (res_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Register copy seen by the predictor; written only at a config transfer
    t_cfg        cfg_model = '{alpha_q8: ALPHA_RST, max_jump_mm: JUMP_RST,
                               first_limit_mm: LIMIT_RST};
    // node_store follows accepted readings, gen_store runs ahead with the queue
    t_node_state node_store [NODE_SLOTS] = '{default: '0};
    t_node_state gen_store  [NODE_SLOTS] = '{default: '0};

    t_reading pending_readings [$];
    t_update  expected_out [$];

    logic smp_taken = 1'b0;
    logic rx_hold   = 1'b0;
    logic hold_go   = 1'b0;
    int   tx_idle_pct = 32;
    int   rx_idle_pct = 49;
    int   mismatches  = 0;
    int   stall_cycles = 0;

    // One filter step for a single node; returns the new node state and the verdict
    function automatic t_update ema_step(t_cfg c, t_node_state cur,
                                         logic [MM_W-1:0] reading_mm);
        t_update upd;
        longint  raw, filt, diff, mag, nxt;
        upd.state    = cur;
        upd.rejected = 1'b0;
        raw  = longint'(reading_mm) <<< FRAC_W;
        filt = longint'(cur.filt);
        if (!cur.seeded) begin
            if (reading_mm != '0 && reading_mm < c.first_limit_mm) begin
                upd.state.seeded = 1'b1;
                upd.state.filt   = {reading_mm, {FRAC_W{1'b0}}};
            end else begin
                upd.rejected = 1'b1;
            end
        end else begin
            diff = raw - filt;
            mag  = (diff < 0) ? -diff : diff;
            if (mag >= (longint'(c.max_jump_mm) <<< FRAC_W)) begin
                upd.rejected = 1'b1;
            end else begin
                // arithmetic shift floors toward minus infinity
                nxt = filt + ((longint'(c.alpha_q8) * diff) >>> FRAC_W);
                if (nxt < 0)
                    nxt = 0;
                else if (nxt > longint'(FILT_MAX))
                    nxt = longint'(FILT_MAX);
                upd.state.filt = nxt[FILT_W-1:0];
            end
        end
        return upd;
    endfunction

    task automatic flag_mismatch(string what, logic [FILT_W-1:0] want, logic [FILT_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected %0h, got %0h", $time, what, want, got);
    endtask

    task automatic queue_reading(logic [NODE_W-1:0] n, logic [MM_W-1:0] reading_mm);
        t_update upd;
        if (n < NODE_COUNT) begin
            upd = ema_step(cfg_model, gen_store[n], reading_mm);
            gen_store[n] = upd.state;
        end
        pending_readings.push_back('{node: n, mm: reading_mm});
    endtask

    task automatic drain();
        while (pending_readings.size() != 0 || smp_if.valid || expected_out.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Mostly in-window readings for seeded nodes, so the blend path dominates, or first
    // readings below the limit for unseeded ones; the rest are window edge or noise.
    task automatic random_phase(int count);
        t_node_state       ns;
        logic [NODE_W-1:0] n;
        logic [MM_W-1:0]   reading_mm;
        longint            centre, off, v;
        int                pick;
        repeat (count) begin
            n    = NODE_W'($urandom_range(NODE_SLOTS - 1));
            ns   = gen_store[n];
            pick = $urandom_range(99);
            if (!ns.seeded && pick < 70 && cfg_model.first_limit_mm > 1) begin
                reading_mm = $urandom_range(cfg_model.first_limit_mm - 1, 1);
            end else if (ns.seeded && pick < 85) begin
                centre = longint'(ns.filt >> FRAC_W);
                if (pick < 75)
                    off = (cfg_model.max_jump_mm == '0) ? 0 :
                          longint'($urandom_range(cfg_model.max_jump_mm - 1));
                else
                    off = longint'(cfg_model.max_jump_mm) + int'($urandom_range(2)) - 1;
                v = $urandom_range(1) ? centre + off : centre - off;
                if (v < 0)
                    v = 0;
                else if (v > longint'({MM_W{1'b1}}))
                    v = longint'({MM_W{1'b1}});
                reading_mm = v[MM_W-1:0];
            end else begin
                case ($urandom_range(4))
                    0:       reading_mm = '0;
                    1:       reading_mm = '1;
                    2:       reading_mm = cfg_model.first_limit_mm;
                    3:       reading_mm = cfg_model.first_limit_mm - 1;
                    default: reading_mm = $urandom;
                endcase
            end
            queue_reading(n, reading_mm);
        end
        drain();
    endtask

    // Sender: valid is held until its transfer, gaps only between items
    always @(negedge i_clk) begin : drive_readings
        t_reading nxt;
        if (smp_if.valid && smp_taken)
            void'(pending_readings.pop_front());
        if (!smp_if.valid || smp_taken) begin
            if (i_rst_n && pending_readings.size() != 0
                    && $urandom_range(99) >= tx_idle_pct) begin
                nxt = pending_readings[0];
                smp_if.valid      <= 1'b1;
                smp_if.node_index <= nxt.node;
                smp_if.range_mm   <= nxt.mm;
            end else begin
                smp_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : drive_ready
        res_if.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // Long receiver hold-off so the block fills and back-pressures its input
    initial begin : rx_hold_off
        wait (hold_go);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    always @(posedge i_clk) begin : watch_ports
        t_update want;
        logic [NODE_W-1:0] n;
        smp_taken <= smp_if.valid && smp_if.ready;

        if (cfg_if.valid && cfg_if.ready) begin
            case (t_cfg_index'(cfg_if.index))
                CFG_ALPHA:       cfg_model.alpha_q8       = cfg_if.data[ALPHA_W-1:0];
                CFG_MAX_JUMP:    cfg_model.max_jump_mm    = cfg_if.data[JUMP_W-1:0];
                CFG_FIRST_LIMIT: cfg_model.first_limit_mm = cfg_if.data[LIMIT_W-1:0];
                default: ;
            endcase
        end

        if (smp_if.valid && smp_if.ready) begin
            n = smp_if.node_index;
            if (n >= NODE_COUNT) begin
                want = '0;
                want.rejected = 1'b1;
            end else begin
                want = ema_step(cfg_model, node_store[n], smp_if.range_mm);
                node_store[n] = want.state;
            end
            expected_out.push_back(want);
        end

        if (res_if.valid && res_if.ready) begin
            if (expected_out.size() == 0) begin
                flag_mismatch("result with nothing expected", '0, res_if.filtered_q8);
            end else begin
                want = expected_out.pop_front();
                if (res_if.node_seeded !== want.state.seeded)
                    flag_mismatch("node_seeded", want.state.seeded, res_if.node_seeded);
                if (res_if.filtered_q8 !== want.state.filt)
                    flag_mismatch("filtered_q8", want.state.filt, res_if.filtered_q8);
                if (res_if.reading_rejected !== want.rejected)
                    flag_mismatch("reading_rejected", want.rejected, res_if.reading_rejected);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        i_rst_n           = 1'b0;
        smp_if.valid      = 1'b0;
        smp_if.node_index = '0;
        smp_if.range_mm   = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = CFG_ALPHA;
        cfg_if.data       = '0;
        res_if.ready      = 1'b0;
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: first-reading window, jump boundary, negative floor, saturation
        queue_reading(0, 0);
        queue_reading(0, 100000);
        queue_reading(0, 99999);
        queue_reading(0, 99999 + 800);     // exactly on the jump limit
        queue_reading(0, 99999 - 799);
        queue_reading(0, '1);
        queue_reading(1, 1);
        queue_reading(1, 0);
        queue_reading(1, 0);               // negative step rounds down
        queue_reading(2, '1);
        drain();
        write_reg(CFG_FIRST_LIMIT, '1);
        write_reg(CFG_MAX_JUMP, 65535);
        queue_reading(2, '1);
        queue_reading(2, 32'hFFFF_FFFD);
        drain();
        write_reg(CFG_ALPHA, 511);
        queue_reading(2, '1);              // overshoot clips at the top
        queue_reading(1, 0);               // overshoot clips at zero
        queue_reading(0, 99999 + 65535);
        drain();
        write_reg(CFG_ALPHA, 256);
        queue_reading(0, 50000);
        drain();
        write_reg(CFG_ALPHA, 0);
        write_reg(CFG_MAX_JUMP, 0);
        queue_reading(0, 50000);           // zero window refuses even a perfect match
        drain();
        write_reg(CFG_MAX_JUMP, 5);
        queue_reading(0, 50003);
        queue_reading(0, 0);
        queue_reading(3, 0);
        drain();
        write_reg(CFG_FIRST_LIMIT, 0);
        queue_reading(3, 1);
        drain();

        write_reg(CFG_ALPHA, 141);
        write_reg(CFG_MAX_JUMP, 800);
        write_reg(CFG_FIRST_LIMIT, 1);
        random_phase(200);
        write_reg(CFG_FIRST_LIMIT, 100000);
        random_phase(200);

        tx_idle_pct = 49;
        rx_idle_pct = 32;
        write_reg(CFG_ALPHA, 0);
        write_reg(CFG_MAX_JUMP, 65535);
        write_reg(CFG_FIRST_LIMIT, '1);
        random_phase(150);
        write_reg(CFG_ALPHA, 256);
        write_reg(CFG_MAX_JUMP, 1);
        write_reg(CFG_FIRST_LIMIT, 1);
        random_phase(120);
        write_reg(CFG_ALPHA, 511);
        write_reg(CFG_MAX_JUMP, 3000);
        write_reg(CFG_FIRST_LIMIT, 5000);
        random_phase(150);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(CFG_ALPHA, $urandom_range(511));
        write_reg(CFG_MAX_JUMP, $urandom_range(65535));
        write_reg(CFG_FIRST_LIMIT, $urandom);
        hold_go = 1'b1;
        random_phase(250);
        write_reg(CFG_ALPHA, 257);
        write_reg(CFG_MAX_JUMP, 0);
        random_phase(40);
        // full-width data: bits above each register's width are dropped
        write_reg(CFG_ALPHA, $urandom);
        write_reg(CFG_MAX_JUMP, $urandom);
        write_reg(CFG_FIRST_LIMIT, $urandom);
        random_phase(150);

        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && expected_out.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
